[rtl/core/rsbs_pkg.sv]
// Package for the range scan breakpoint segmenter.
// Holds the item types, configuration types, register indexes and sizing constants.
// Used by every module of the block; it depends on nothing else.
package rsbs_pkg;

    localparam int MAX_SAMPLES = 4096;
    localparam int IDX_W       = $clog2(MAX_SAMPLES);
    localparam int LEN_W       = IDX_W + 1;
    localparam int MINP_W      = 13;
    localparam int CMP_W       = (LEN_W > MINP_W) ? LEN_W : MINP_W;
    localparam int OUT_IDX_W   = 12;
    localparam int RANGE_W     = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int PROD_W      = 2 * (RANGE_W + 1);

    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_SAMPLES - 1);

    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int OQ_DEPTH    = 4;
    localparam int OQPTR_W     = $clog2(OQ_DEPTH);
    localparam int OQCNT_W     = $clog2(OQ_DEPTH + 1);

    localparam logic [MINP_W-1:0]  RST_MIN_SEG_LEN = MINP_W'(2);
    localparam logic [RANGE_W-1:0] RST_DIST_0      = RANGE_W'(0);
    localparam logic [RANGE_W-1:0] RST_DIST_1      = RANGE_W'(1000);
    localparam logic [RANGE_W-1:0] RST_DIST_2      = RANGE_W'(4000);
    localparam logic [RANGE_W-1:0] RST_ERR         = RANGE_W'(50);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_SEG_LEN = 3'd0,
        CFG_DIST_0      = 3'd1,
        CFG_ERR_0       = 3'd2,
        CFG_DIST_1      = 3'd3,
        CFG_ERR_1       = 3'd4,
        CFG_DIST_2      = 3'd5,
        CFG_ERR_2       = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [MINP_W-1:0]  min_seg_len;
        logic [RANGE_W-1:0] dist0;
        logic [RANGE_W-1:0] err0;
        logic [RANGE_W-1:0] dist1;
        logic [RANGE_W-1:0] err1;
        logic [RANGE_W-1:0] dist2;
        logic [RANGE_W-1:0] err2;
    } cfg_t;

    typedef struct packed {
        logic [RANGE_W-1:0] sample_range;
        logic               scan_end;
    } in_item_t;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] seg_start;
        logic [OUT_IDX_W-1:0] seg_end;
        logic                 last_of_run;
    } out_item_t;

    typedef struct packed {
        logic             brk;
        logic             scan_end;
        logic             first;
        logic [IDX_W-1:0] prev_idx;
        logic [IDX_W-1:0] idx;
    } seg_item_t;

endpackage

[rtl/core/rsbs_front.sv]
// Front part of the segmenter: accepts samples, tracks indexes and runs the breakpoint test.
// Three registered stages: neighbor compare, table interpolation operands, cross products.
// Depends on rsbs_pkg.
module rsbs_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rsbs_pkg::cfg_t                cfg,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  rsbs_pkg::in_item_t            in_data,
    input  logic [rsbs_pkg::QCNT_W-1:0]   q_count,
    output logic                          q_push,
    output rsbs_pkg::seg_item_t           q_item
);

    logic                                   in_accept;
    logic [rsbs_pkg::QCNT_W-1:0]            inflight;

    logic [rsbs_pkg::RANGE_W-1:0]           prev_range_reg, prev_range_next;
    logic                                   have_prev_reg, have_prev_next;
    logic [rsbs_pkg::IDX_W-1:0]             sample_index_reg, sample_index_next;

    logic [rsbs_pkg::IDX_W-1:0]             idx_new;
    logic [rsbs_pkg::RANGE_W-1:0]           lo_new, diff_new;
    rsbs_pkg::seg_item_t                    item_new;

    logic                                   s1_valid_reg;
    rsbs_pkg::seg_item_t                    s1_item_reg;
    logic [rsbs_pkg::RANGE_W-1:0]           s1_lo_reg, s1_diff_reg;

    logic                                   below, above, upper;
    logic [rsbs_pkg::RANGE_W-1:0]           dl, dr, el, er, err_direct;
    logic                                   direct_next, hit_next;
    logic signed [rsbs_pkg::RANGE_W:0]      a_next, derr_next;
    logic [rsbs_pkg::RANGE_W-1:0]           span_next, off_next;

    logic                                   s2_valid_reg;
    rsbs_pkg::seg_item_t                    s2_item_reg;
    logic                                   s2_direct_reg, s2_hit_reg;
    logic signed [rsbs_pkg::RANGE_W:0]      s2_a_reg, s2_derr_reg;
    logic [rsbs_pkg::RANGE_W-1:0]           s2_span_reg, s2_off_reg;
    logic signed [rsbs_pkg::RANGE_W:0]      span_s, off_s;
    logic signed [rsbs_pkg::PROD_W-1:0]     prod_l_next, prod_r_next;

    logic                                   s3_valid_reg;
    rsbs_pkg::seg_item_t                    s3_item_reg;
    logic                                   s3_direct_reg, s3_hit_reg;
    logic signed [rsbs_pkg::PROD_W-1:0]     s3_prod_l_reg, s3_prod_r_reg;

    // Every item in the pipeline holds a queue slot, so pushes never overflow.
    assign inflight = q_count + rsbs_pkg::QCNT_W'(s1_valid_reg)
                    + rsbs_pkg::QCNT_W'(s2_valid_reg) + rsbs_pkg::QCNT_W'(s3_valid_reg);
    assign in_stall  = (inflight >= rsbs_pkg::QCNT_W'(rsbs_pkg::QUEUE_DEPTH));
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        if (!have_prev_reg)
        begin
            idx_new = '0;
        end
        else if (sample_index_reg == rsbs_pkg::IDX_MAX)
        begin
            idx_new = rsbs_pkg::IDX_MAX;
        end
        else
        begin
            idx_new = sample_index_reg + rsbs_pkg::IDX_W'(1);
        end

        if (prev_range_reg < in_data.sample_range)
        begin
            lo_new   = prev_range_reg;
            diff_new = in_data.sample_range - prev_range_reg;
        end
        else
        begin
            lo_new   = in_data.sample_range;
            diff_new = prev_range_reg - in_data.sample_range;
        end

        item_new.brk      = 1'b0;
        item_new.scan_end = in_data.scan_end;
        item_new.first    = !have_prev_reg;
        item_new.prev_idx = sample_index_reg;
        item_new.idx      = idx_new;

        prev_range_next   = prev_range_reg;
        have_prev_next    = have_prev_reg;
        sample_index_next = sample_index_reg;
        if (in_accept)
        begin
            if (in_data.scan_end)
            begin
                prev_range_next   = '0;
                have_prev_next    = 1'b0;
                sample_index_next = '0;
            end
            else
            begin
                prev_range_next   = in_data.sample_range;
                have_prev_next    = 1'b1;
                sample_index_next = idx_new;
            end
        end
    end

    always_comb
    begin
        below = s1_lo_reg < cfg.dist0;
        above = s1_lo_reg > cfg.dist2;
        upper = s1_lo_reg > cfg.dist1;
        dl    = upper ? cfg.dist1 : cfg.dist0;
        dr    = upper ? cfg.dist2 : cfg.dist1;
        el    = upper ? cfg.err1  : cfg.err0;
        er    = upper ? cfg.err2  : cfg.err1;

        if (below)
        begin
            err_direct = cfg.err0;
        end
        else if (above)
        begin
            err_direct = cfg.err2;
        end
        else
        begin
            err_direct = el;
        end

        direct_next = below || above || (dr <= dl);
        hit_next    = s1_diff_reg > err_direct;
        a_next      = $signed({1'b0, s1_diff_reg}) - $signed({1'b0, el});
        derr_next   = $signed({1'b0, er}) - $signed({1'b0, el});
        span_next   = dr - dl;
        off_next    = s1_lo_reg - dl;
    end

    assign span_s      = $signed({1'b0, s2_span_reg});
    assign off_s       = $signed({1'b0, s2_off_reg});
    assign prod_l_next = s2_a_reg * span_s;
    assign prod_r_next = off_s * s2_derr_reg;

    always_comb
    begin
        q_push = s3_valid_reg;
        q_item = s3_item_reg;
        if (s3_item_reg.first)
        begin
            q_item.brk = 1'b0;
        end
        else if (s3_direct_reg)
        begin
            q_item.brk = s3_hit_reg;
        end
        else
        begin
            q_item.brk = s3_prod_l_reg > s3_prod_r_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_range_reg   <= '0;
            have_prev_reg    <= 1'b0;
            sample_index_reg <= '0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
        end
        else
        begin
            prev_range_reg   <= prev_range_next;
            have_prev_reg    <= have_prev_next;
            sample_index_reg <= sample_index_next;
            s1_valid_reg     <= in_accept;
            s2_valid_reg     <= s1_valid_reg;
            s3_valid_reg     <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_item_reg   <= item_new;
        s1_lo_reg     <= lo_new;
        s1_diff_reg   <= diff_new;
        s2_item_reg   <= s1_item_reg;
        s2_direct_reg <= direct_next;
        s2_hit_reg    <= hit_next;
        s2_a_reg      <= a_next;
        s2_derr_reg   <= derr_next;
        s2_span_reg   <= span_next;
        s2_off_reg    <= off_next;
        s3_item_reg   <= s2_item_reg;
        s3_direct_reg <= s2_direct_reg;
        s3_hit_reg    <= s2_hit_reg;
        s3_prod_l_reg <= prod_l_next;
        s3_prod_r_reg <= prod_r_next;
    end

endmodule

[rtl/core/rsbs_queue.sv]
// Short queue of classified items between the front and back parts.
// Holds rsbs_pkg::QUEUE_DEPTH entries; depends on rsbs_pkg.
module rsbs_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  rsbs_pkg::seg_item_t           push_item,
    input  logic                          pop,
    output logic                          head_valid,
    output rsbs_pkg::seg_item_t           head_item,
    output logic [rsbs_pkg::QCNT_W-1:0]   count
);

    rsbs_pkg::seg_item_t                  mem [rsbs_pkg::QUEUE_DEPTH];
    logic [rsbs_pkg::QPTR_W-1:0]          wr_ptr_reg, wr_ptr_next;
    logic [rsbs_pkg::QPTR_W-1:0]          rd_ptr_reg, rd_ptr_next;
    logic [rsbs_pkg::QCNT_W-1:0]          count_reg, count_next;

    assign head_valid = (count_reg != '0);
    assign head_item  = mem[rd_ptr_reg];
    assign count      = count_reg;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + rsbs_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + rsbs_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + rsbs_pkg::QCNT_W'(push) - rsbs_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[rtl/core/rsbs_back.sv]
// Back part of the segmenter: keeps the open segment and forms the reported index pairs.
// Results wait in a small output queue: up to two per cycle, while two entries are free.
// Depends on rsbs_pkg.
module rsbs_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [rsbs_pkg::MINP_W-1:0]   min_seg_len,
    input  logic                          q_valid,
    input  rsbs_pkg::seg_item_t           q_item,
    output logic                          q_pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output rsbs_pkg::out_item_t           out_data
);

    logic [rsbs_pkg::IDX_W-1:0]           seg_first_reg, seg_first_next;
    logic [rsbs_pkg::IDX_W-1:0]           first_eff, first_new;
    logic [rsbs_pkg::LEN_W-1:0]           len_a, len_b;
    logic                                 emit_a, emit_b, out_pop;
    rsbs_pkg::out_item_t                  res_a, res_b;

    rsbs_pkg::out_item_t                  oq_mem [rsbs_pkg::OQ_DEPTH];
    logic [rsbs_pkg::OQPTR_W-1:0]         wr_ptr_reg, wr_ptr_next, wr_ptr_b;
    logic [rsbs_pkg::OQPTR_W-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [rsbs_pkg::OQCNT_W-1:0]         count_reg, count_next;

    assign out_valid = (count_reg != '0);
    assign out_data  = oq_mem[rd_ptr_reg];
    assign out_pop   = out_valid && !out_stall;
    assign q_pop     = q_valid
                    && (count_reg <= rsbs_pkg::OQCNT_W'(rsbs_pkg::OQ_DEPTH - 2));

    always_comb
    begin
        first_eff = q_item.first ? '0 : seg_first_reg;
        first_new = q_item.brk ? q_item.idx : first_eff;

        len_a = {1'b0, q_item.prev_idx} - {1'b0, first_eff} + rsbs_pkg::LEN_W'(1);
        len_b = {1'b0, q_item.idx} - {1'b0, first_new} + rsbs_pkg::LEN_W'(1);

        emit_a = q_pop && q_item.brk
              && (rsbs_pkg::CMP_W'(len_a) >= rsbs_pkg::CMP_W'(min_seg_len));
        emit_b = q_pop && q_item.scan_end
              && (rsbs_pkg::CMP_W'(len_b) >= rsbs_pkg::CMP_W'(min_seg_len));

        res_a.seg_start   = rsbs_pkg::OUT_IDX_W'(first_eff);
        res_a.seg_end     = rsbs_pkg::OUT_IDX_W'(q_item.prev_idx);
        res_a.last_of_run = !emit_b;
        res_b.seg_start   = rsbs_pkg::OUT_IDX_W'(first_new);
        res_b.seg_end     = rsbs_pkg::OUT_IDX_W'(q_item.idx);
        res_b.last_of_run = 1'b1;

        seg_first_next = seg_first_reg;
        if (q_pop)
        begin
            seg_first_next = q_item.scan_end ? '0 : first_new;
        end

        wr_ptr_b    = wr_ptr_reg + rsbs_pkg::OQPTR_W'(emit_a);
        wr_ptr_next = wr_ptr_b + rsbs_pkg::OQPTR_W'(emit_b);
        rd_ptr_next = out_pop ? rd_ptr_reg + rsbs_pkg::OQPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + rsbs_pkg::OQCNT_W'(emit_a) + rsbs_pkg::OQCNT_W'(emit_b)
                    - rsbs_pkg::OQCNT_W'(out_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_first_reg <= '0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
        end
        else
        begin
            seg_first_reg <= seg_first_next;
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_a)
        begin
            oq_mem[wr_ptr_reg] <= res_a;
        end
        if (emit_b)
        begin
            oq_mem[wr_ptr_b] <= res_b;
        end
    end

endmodule

[rtl/core/range_scan_breakpoint_segmenter.sv]
// Top level of the range scan breakpoint segmenter: configuration registers and the
// front, queue and back parts. Depends on rsbs_pkg, rsbs_front, rsbs_queue and rsbs_back.
//
//  Channel | Handshake                  | Payload
//  --------+----------------------------+------------------------------------------
//  in      | in_valid / in_stall        | in_data: sample_range, scan_end
//  out     | out_valid / out_stall      | out_data: seg_start, seg_end, last_of_run
//  cfg     | cfg_write                  | cfg_index, cfg_data
//
// One item is accepted per cycle when the output side keeps up.
// A result passes the three front stages, the queue and the back's output queue before it leaves.
// Results leave one per cycle while out_stall is low; an item's two results leave in turn.
// Reset clears the scan state and both queues, and loads the default table.
// in_stall rises when the eight queue slots, counting items still in the front, are taken.
module range_scan_breakpoint_segmenter (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  rsbs_pkg::in_item_t                 in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output rsbs_pkg::out_item_t                out_data,
    input  logic                               cfg_write,
    input  logic [rsbs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rsbs_pkg::CFG_DATA_W-1:0]    cfg_data
);

    rsbs_pkg::cfg_t                   cfg_reg, cfg_next;
    logic [rsbs_pkg::QCNT_W-1:0]      q_count;
    logic                             q_push, q_pop, q_valid;
    rsbs_pkg::seg_item_t              q_push_item, q_head_item;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                rsbs_pkg::CFG_MIN_SEG_LEN:
                    cfg_next.min_seg_len = cfg_data[rsbs_pkg::MINP_W-1:0];
                rsbs_pkg::CFG_DIST_0:     cfg_next.dist0      = cfg_data;
                rsbs_pkg::CFG_ERR_0:      cfg_next.err0       = cfg_data;
                rsbs_pkg::CFG_DIST_1:     cfg_next.dist1      = cfg_data;
                rsbs_pkg::CFG_ERR_1:      cfg_next.err1       = cfg_data;
                rsbs_pkg::CFG_DIST_2:     cfg_next.dist2      = cfg_data;
                rsbs_pkg::CFG_ERR_2:      cfg_next.err2       = cfg_data;
                default:                  cfg_next            = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_seg_len <= rsbs_pkg::RST_MIN_SEG_LEN;
            cfg_reg.dist0       <= rsbs_pkg::RST_DIST_0;
            cfg_reg.err0        <= rsbs_pkg::RST_ERR;
            cfg_reg.dist1       <= rsbs_pkg::RST_DIST_1;
            cfg_reg.err1        <= rsbs_pkg::RST_ERR;
            cfg_reg.dist2       <= rsbs_pkg::RST_DIST_2;
            cfg_reg.err2        <= rsbs_pkg::RST_ERR;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    rsbs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_count  (q_count),
        .q_push   (q_push),
        .q_item   (q_push_item)
    );

    rsbs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (q_push_item),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_item  (q_head_item),
        .count      (q_count)
    );

    rsbs_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .min_seg_len (cfg_reg.min_seg_len),
        .q_valid     (q_valid),
        .q_item      (q_head_item),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

endmodule

[rtl/core/rsbs_checker.sv]
// Port-level checks for the range scan breakpoint segmenter, bound to the top level.
// Depends on rsbs_pkg and range_scan_breakpoint_segmenter.
module rsbs_checker (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  rsbs_pkg::in_item_t    in_data,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  rsbs_pkg::out_item_t   out_data
);

    logic seen_reg, seen_next;

    assign seen_next = seen_reg || (in_valid && !in_stall && (in_data.scan_end || 1'b1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= 1'b0;
        end
        else
        begin
            seen_reg <= seen_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        !seen_reg |-> !out_valid)
        else $error("Result shown before any sample was accepted.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.seg_start <= out_data.seg_end))
        else $error("Segment start lies after its end.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !out_data.last_of_run) |=> out_valid)
        else $error("Second result of a sample did not follow.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
        else $error("Stalled result changed or vanished.");

endmodule

bind range_scan_breakpoint_segmenter rsbs_checker u_rsbs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

[test/range_scan_breakpoint_segmenter_tb.sv]
// Self-checking testbench for range_scan_breakpoint_segmenter: a local segment predictor,
// directed scans for the default table, interpolation, table corners and long scans,
// then random scans. Depends on rsbs_pkg and the block's RTL only.
module range_scan_breakpoint_segmenter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rsbs_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = '1;
    localparam int DRAIN_CYCLES    = 24;
    localparam int WATCHDOG_CYCLES = 4000;
    localparam int RANDOM_PHASES   = 10;
    localparam int PHASE_SAMPLES   = 140;

    logic      clk;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_data;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Predictor copy of the registers and the scan state.
    logic [MINP_W-1:0]  cur_min_seg_len = RST_MIN_SEG_LEN;
    logic [RANGE_W-1:0] cur_dist [3] = '{RST_DIST_0, RST_DIST_1, RST_DIST_2};
    logic [RANGE_W-1:0] cur_err  [3] = '{RST_ERR, RST_ERR, RST_ERR};
    logic [RANGE_W-1:0] scan_prev_range = '0;
    bit                 scan_have_prev = 1'b0;
    int unsigned        scan_last_idx = 0;
    int unsigned        scan_seg_first = 0;

    out_item_t   segments_due [$];
    out_item_t   seg_want;
    int unsigned burst_left = 0;
    int unsigned samples_sent = 0;
    int unsigned segments_checked = 0;
    int unsigned config_loads = 0;
    int unsigned error_count = 0;
    int unsigned stall_mode = 0;
    int unsigned stall_span = 0;
    int unsigned stall_hold = 0;
    int unsigned stall_tick = 0;

    range_scan_breakpoint_segmenter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic in_item_t sample_of(input int unsigned r, input bit e);
        in_item_t s;
        s.sample_range = RANGE_W'(r);
        s.scan_end     = e;
        return s;
    endfunction

    function automatic cfg_t table_cfg(input int unsigned minp,
                                       input int unsigned d0, input int unsigned e0,
                                       input int unsigned d1, input int unsigned e1,
                                       input int unsigned d2, input int unsigned e2);
        cfg_t c;
        c.min_seg_len = MINP_W'(minp);
        c.dist0 = RANGE_W'(d0);
        c.err0  = RANGE_W'(e0);
        c.dist1 = RANGE_W'(d1);
        c.err1  = RANGE_W'(e1);
        c.dist2 = RANGE_W'(d2);
        c.err2  = RANGE_W'(e2);
        return c;
    endfunction

    // Exact test of diff against the error interpolated at range d.
    function automatic bit is_breakpoint(input int unsigned diff, input int unsigned d);
        longint dl;
        longint dr;
        longint el;
        longint er;
        longint span;
        int     k;
        if (d < cur_dist[0])
            return diff > cur_err[0];
        if (d > cur_dist[2])
            return diff > cur_err[2];
        k    = (d <= cur_dist[1]) ? 0 : 1;
        dl   = cur_dist[k];
        dr   = cur_dist[k + 1];
        el   = cur_err[k];
        er   = cur_err[k + 1];
        span = dr - dl;
        if (span <= 0)
            return diff > cur_err[k];
        return longint'(diff) * span > el * span + (longint'(d) - dl) * (er - el);
    endfunction

    function automatic bit long_enough(input int unsigned first, input int unsigned last);
        return (last - first + 1) >= cur_min_seg_len;
    endfunction

    task automatic track_sample(input in_item_t s);
        int unsigned r;
        int unsigned lo;
        int unsigned diff;
        int unsigned idx;
        out_item_t   segs [2];
        int          n;
        n = 0;
        r = s.sample_range;
        if (!scan_have_prev) begin
            idx = 0;
            scan_seg_first = 0;
        end else begin
            lo   = (scan_prev_range < r) ? scan_prev_range : r;
            diff = (scan_prev_range > r) ? scan_prev_range - r : r - scan_prev_range;
            idx  = scan_last_idx + 1;
            if (idx > MAX_SAMPLES - 1)
                idx = MAX_SAMPLES - 1;
            if (is_breakpoint(diff, lo)) begin
                if (long_enough(scan_seg_first, scan_last_idx)) begin
                    segs[n].seg_start   = OUT_IDX_W'(scan_seg_first);
                    segs[n].seg_end     = OUT_IDX_W'(scan_last_idx);
                    segs[n].last_of_run = 1'b0;
                    n++;
                end
                scan_seg_first = idx;
            end
        end
        if (s.scan_end) begin
            if (long_enough(scan_seg_first, idx)) begin
                segs[n].seg_start   = OUT_IDX_W'(scan_seg_first);
                segs[n].seg_end     = OUT_IDX_W'(idx);
                segs[n].last_of_run = 1'b0;
                n++;
            end
            scan_prev_range = '0;
            scan_have_prev  = 1'b0;
            scan_last_idx   = 0;
            scan_seg_first  = 0;
        end else begin
            scan_prev_range = s.sample_range;
            scan_have_prev  = 1'b1;
            scan_last_idx   = idx;
        end
        if (n > 0)
            segs[n - 1].last_of_run = 1'b1;
        for (int i = 0; i < n; i++)
            segments_due = {segments_due, segs[i]};
    endtask

    task automatic send_sample(input in_item_t s);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(24, 96)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= s;
        do @(posedge clk); while (in_stall);
        track_sample(s);
        samples_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (segments_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic load_config(input cfg_t c);
        cfg_write <= 1'b1;
        cfg_index <= CFG_UNUSED;
        cfg_data  <= CFG_DATA_W'($urandom);
        @(posedge clk);
        cfg_index <= CFG_MIN_SEG_LEN;
        cfg_data  <= {3'($urandom), c.min_seg_len};
        @(posedge clk);
        cfg_index <= CFG_DIST_0;
        cfg_data  <= c.dist0;
        @(posedge clk);
        cfg_index <= CFG_ERR_0;
        cfg_data  <= c.err0;
        @(posedge clk);
        cfg_index <= CFG_DIST_1;
        cfg_data  <= c.dist1;
        @(posedge clk);
        cfg_index <= CFG_ERR_1;
        cfg_data  <= c.err1;
        @(posedge clk);
        cfg_index <= CFG_DIST_2;
        cfg_data  <= c.dist2;
        @(posedge clk);
        cfg_index <= CFG_ERR_2;
        cfg_data  <= c.err2;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        cur_min_seg_len = c.min_seg_len;
        cur_dist[0] = c.dist0;
        cur_err[0]  = c.err0;
        cur_dist[1] = c.dist1;
        cur_err[1]  = c.err1;
        cur_dist[2] = c.dist2;
        cur_err[2]  = c.err2;
        config_loads++;
    endtask

    function automatic cfg_t random_cfg(input int unsigned kind);
        cfg_t        c;
        int unsigned d0;
        int unsigned d1;
        int unsigned d2;
        int unsigned e;
        d0 = $urandom_range(0, 20000);
        d1 = d0 + $urandom_range(1, 20000);
        d2 = d1 + $urandom_range(1, 25000);
        case (kind)
            0: c = table_cfg(0, d0, $urandom_range(0, 2000), d1, $urandom_range(0, 2000),
                             d2, $urandom_range(0, 2000));
            1: begin
                e = $urandom_range(0, 1500);
                c = table_cfg(0, d0, e, d1, e, d2, e);
            end
            2: c = table_cfg(0, $urandom_range(0, 65535), $urandom_range(0, 65535),
                             $urandom_range(0, 65535), $urandom_range(0, 65535),
                             $urandom_range(0, 65535), $urandom_range(0, 65535));
            3: begin
                if ($urandom_range(0, 1) == 0)
                    d1 = d0;
                else
                    d2 = d1;
                c = table_cfg(0, d0, $urandom_range(0, 3000), d1, $urandom_range(0, 3000),
                              d2, $urandom_range(0, 3000));
            end
            default: c = table_cfg(0, 65535 * $urandom_range(0, 1), 65535 * $urandom_range(0, 1),
                                   65535 * $urandom_range(0, 1), 65535 * $urandom_range(0, 1),
                                   65535 * $urandom_range(0, 1), 65535 * $urandom_range(0, 1));
        endcase
        case ($urandom_range(0, 8))
            0: c.min_seg_len = '0;
            1: c.min_seg_len = MINP_W'(1);
            2: c.min_seg_len = MINP_W'(2);
            3: c.min_seg_len = MINP_W'($urandom_range(3, 6));
            4: c.min_seg_len = '1;
            5: c.min_seg_len = MINP_W'(4096);
            6: c.min_seg_len = MINP_W'($urandom_range(0, 8191));
            default: c.min_seg_len = MINP_W'($urandom_range(0, 12));
        endcase
        return c;
    endfunction

    task automatic test_default_table();
        send_sample(sample_of(0, 1));
        send_sample(sample_of(1000, 0));
        send_sample(sample_of(1050, 0));
        send_sample(sample_of(1101, 1));
        send_sample(sample_of(65535, 0));
        send_sample(sample_of(0, 1));
        send_sample(sample_of(10, 0));
        send_sample(sample_of(20, 0));
        send_sample(sample_of(30, 0));
        send_sample(sample_of(40, 1));
    endtask

    task automatic test_table_interp();
        wait_idle();
        load_config(table_cfg(1, 1000, 10, 2000, 110, 4000, 1000));
        send_sample(sample_of(777, 1));
        send_sample(sample_of(500, 0));
        send_sample(sample_of(511, 1));
        send_sample(sample_of(1500, 0));
        send_sample(sample_of(1560, 0));
        send_sample(sample_of(1619, 0));
        send_sample(sample_of(65535, 1));
        send_sample(sample_of(60000, 0));
        send_sample(sample_of(61000, 1));
    endtask

    task automatic test_table_corners();
        wait_idle();
        load_config(table_cfg(0, 1000, 200, 1000, 5, 3000, 900));
        send_sample(sample_of(1000, 0));
        send_sample(sample_of(1150, 0));
        send_sample(sample_of(1000, 1));
        wait_idle();
        load_config(table_cfg(0, 1000, 0, 3000, 600, 2000, 40));
        send_sample(sample_of(2500, 0));
        send_sample(sample_of(2800, 1));
        send_sample(sample_of(1500, 0));
        send_sample(sample_of(1700, 1));
        wait_idle();
        load_config(table_cfg(1, 65535, 0, 65535, 0, 65535, 0));
        send_sample(sample_of(65535, 0));
        send_sample(sample_of(65535, 0));
        send_sample(sample_of(65534, 1));
    endtask

    task automatic test_long_scans();
        int unsigned k;
        int unsigned level;
        wait_idle();
        load_config(table_cfg(150, 0, 100, 1000, 100, 4000, 100));
        level = 5000;
        for (k = 0; k < 300; k++) begin
            if (k == 100)
                level = 9000;
            else if (k == 290)
                level = 20000;
            send_sample(sample_of(level + $urandom_range(0, 40), k == 299));
        end
        wait_idle();
        load_config(table_cfg(1, 0, 100, 1000, 100, 4000, 100));
        level = 5000;
        for (k = 0; k < 30; k++) begin
            if (k == 10)
                level = 9000;
            else if (k == 25)
                level = 20000;
            else if (k == 28)
                level = 30000;
            send_sample(sample_of(level + $urandom_range(0, 40), k == 29));
        end
    endtask

    task automatic test_random_scans();
        int unsigned phase;
        int unsigned sent;
        int unsigned len;
        int unsigned jitter;
        int unsigned k;
        int          level;
        bit          noisy;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_idle();
            load_config(random_cfg(phase % 5));
            sent = 0;
            while (sent < PHASE_SAMPLES) begin
                len   = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3)
                                                    : $urandom_range(4, 48);
                noisy = ($urandom_range(0, 9) == 0);
                case ($urandom_range(0, 5))
                    0: jitter = 0;
                    1: jitter = 8;
                    2: jitter = 30;
                    3: jitter = 120;
                    4: jitter = 500;
                    default: jitter = 2000;
                endcase
                level = $urandom_range(0, 65535);
                for (k = 0; k < len; k++) begin
                    if (noisy || $urandom_range(0, 11) == 0) begin
                        level = $urandom_range(0, 65535);
                    end else begin
                        level = level + int'($urandom_range(0, 2 * jitter)) - int'(jitter);
                        if (level < 0)
                            level = 0;
                        else if (level > 65535)
                            level = 65535;
                    end
                    send_sample(sample_of(level, k == len - 1));
                    sent++;
                end
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (stall_span == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_span = $urandom_range(20, 300);
        end
        stall_span--;
        stall_tick++;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 1) == 1);
            2: out_stall <= (stall_tick % 4 != 0);
            default: begin
                if (stall_hold > 0) begin
                    stall_hold--;
                    out_stall <= 1'b1;
                end else if ($urandom_range(0, 9) == 0) begin
                    stall_hold = $urandom_range(1, 12);
                    out_stall <= 1'b1;
                end else begin
                    out_stall <= 1'b0;
                end
            end
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall) begin
            if (segments_due.size() == 0) begin
                $error("unexpected segment: seg_start=%0d seg_end=%0d last_of_run=%0d",
                       out_data.seg_start, out_data.seg_end, out_data.last_of_run);
                error_count++;
            end else begin
                seg_want = segments_due.pop_front();
                if (out_data.seg_start !== seg_want.seg_start) begin
                    $error("seg_start: expected %0d, actual %0d",
                           seg_want.seg_start, out_data.seg_start);
                    error_count++;
                end
                if (out_data.seg_end !== seg_want.seg_end) begin
                    $error("seg_end: expected %0d, actual %0d",
                           seg_want.seg_end, out_data.seg_end);
                    error_count++;
                end
                if (out_data.last_of_run !== seg_want.last_of_run) begin
                    $error("last_of_run: expected %0d, actual %0d",
                           seg_want.last_of_run, out_data.last_of_run);
                    error_count++;
                end
                segments_checked++;
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_CYCLES) begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("Watchdog expired with %0d segments outstanding.", segments_due.size());
        $display("[range_scan_breakpoint_segmenter] ERROR");
        $finish;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_table();
        test_table_interp();
        test_table_corners();
        test_long_scans();
        test_random_scans();
        wait_idle();
        $display("Sent %0d samples under %0d register settings; %0d segments checked.",
                 samples_sent, config_loads + 1, segments_checked);
        $display("Long scans, table corners and random scans done, %0d mismatches.",
                 error_count);
        if (error_count == 0)
            $display("[range_scan_breakpoint_segmenter] OK");
        else
            $display("[range_scan_breakpoint_segmenter] ERROR");
        $finish;
    end

endmodule

[files.f]
rtl/core/rsbs_pkg.sv
rtl/core/rsbs_front.sv
rtl/core/rsbs_queue.sv
rtl/core/rsbs_back.sv
rtl/core/range_scan_breakpoint_segmenter.sv
rtl/core/rsbs_checker.sv
test/range_scan_breakpoint_segmenter_tb.sv
